@@ sv/assert_macros.svh @@
// Assertion macros of the predictor RTL, used by the controller.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define BBP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define BBP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/bbp_pkg.sv @@
// Shared types and constants of the bimodal branch predictor.
// Used by the interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps
package bbp_pkg;

	localparam int TableEntriesDef = 16;
	// Width of the instruction index space; next_index wraps within it.
	localparam int IndexBits = 16;
	localparam int IdxW      = 16;
	localparam int TgtW      = 18;
	localparam int ValW      = 32;
	localparam int KindW     = 3;
	localparam int CtrW      = 3;

	localparam logic [IdxW-1:0] NextMask = (IndexBits >= IdxW) ? {IdxW{1'b1}} :
		IdxW'((32'd1 << IndexBits) - 32'd1);

	localparam logic [CtrW-1:0] CtrReset = 3'd3;
	localparam logic [CtrW-1:0] CtrMax   = 3'd7;
	localparam logic [CtrW-1:0] CtrZero  = 3'd0;

	localparam logic OpPredict = 1'b0;
	localparam logic OpResolve = 1'b1;

	localparam logic [KindW-1:0] KindBez  = 3'd0;
	localparam logic [KindW-1:0] KindBgez = 3'd1;
	localparam logic [KindW-1:0] KindBlez = 3'd2;
	localparam logic [KindW-1:0] KindBgtz = 3'd3;
	localparam logic [KindW-1:0] KindBltz = 3'd4;

	typedef struct packed {
		logic clear;     // write the reset value at the sweep address
		logic capture;   // take a request word
		logic quot_ld;   // load the index quotient
		logic rem_ld;    // load the slot from the quotient
		logic rd;        // read the table entry of the captured slot
		logic finish;    // load the response and, on a branch resolve, update the entry
	} ctl_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic out_free;
	} dp_stat_t;

endpackage

@@ sv/bbp_if.sv @@
// Valid/ready channel interfaces of the predictor: request and response.
// Depends on bbp_pkg for the field widths.
`timescale 1ns / 1ps
interface bbp_req_if;
	logic                                valid;
	logic                                ready;
	logic                                op;
	logic [bbp_pkg::IdxW-1:0]            instr_index;
	logic [bbp_pkg::KindW-1:0]           branch_kind;
	logic signed [bbp_pkg::ValW-1:0]     test_value;
	logic [bbp_pkg::TgtW-1:0]            target_addr;

	modport source (output valid, op, instr_index, branch_kind, test_value, target_addr,
		input ready);
	modport sink (input valid, op, instr_index, branch_kind, test_value, target_addr,
		output ready);
endinterface

interface bbp_rsp_if;
	logic                     valid;
	logic                     ready;
	logic                     predict_taken;
	logic                     taken;
	logic                     mispredict;
	logic [bbp_pkg::IdxW-1:0] next_index;

	modport source (output valid, predict_taken, taken, mispredict, next_index,
		input ready);
	modport sink (input valid, predict_taken, taken, mispredict, next_index,
		output ready);
endinterface

@@ sv/bbp_ctrl.sv @@
// Controller of the predictor: clearing sweep, remainder steps, table read
// and response load. Depends on bbp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bbp_ctrl #(
	parameter int TableEntries = bbp_pkg::TableEntriesDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  bbp_pkg::dp_stat_t   stat,
	output bbp_pkg::ctl_cmd_t   cmd
);

	localparam bit IsPow2 = (TableEntries & (TableEntries - 1)) == 0;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_QUOT,
		ST_REM,
		ST_READ,
		ST_EVAL
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (stat.clear_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (req_valid) state_q <= IsPow2 ? ST_READ : ST_QUOT;
				end
				ST_QUOT: begin
					state_q <= ST_REM;
				end
				ST_REM: begin
					state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (stat.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	always_comb begin
		req_ready    = (state_q == ST_IDLE);
		cmd.clear    = (state_q == ST_CLEAR);
		cmd.capture  = (state_q == ST_IDLE) && req_valid;
		cmd.quot_ld  = (state_q == ST_QUOT);
		cmd.rem_ld   = (state_q == ST_REM);
		cmd.rd       = (state_q == ST_READ);
		cmd.finish   = (state_q == ST_EVAL) && stat.out_free;
	end

	`BBP_ASSERT(a_finish_free, clk, arst_n, cmd.finish |-> stat.out_free, "response loaded over a waiting word")
	`BBP_ASSERT(a_no_take_clear, clk, arst_n, (state_q == ST_CLEAR) |-> !cmd.capture, "request taken during clearing sweep")
	`BBP_ASSERT(a_one_at_a_time, clk, arst_n, cmd.capture |=> !req_ready, "second request taken while one is in progress")
	`BBP_ASSERT(a_read_before_eval, clk, arst_n, $rose(state_q == ST_EVAL) |-> $past(cmd.rd), "response built without a table read")
	`BBP_ASSERT_ALWAYS(a_wr_exclusive, clk, !arst_n || !(cmd.clear && cmd.finish), "clear and update write at once")

endmodule

@@ sv/bbp_dp.sv @@
// Datapath of the predictor: request registers, index remainder, counter
// table, condition evaluation and response register. Depends on bbp_pkg.
`timescale 1ns / 1ps
module bbp_dp #(
	parameter int TableEntries = bbp_pkg::TableEntriesDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bbp_pkg::ctl_cmd_t  cmd,
	output bbp_pkg::dp_stat_t  stat,
	bbp_req_if.sink            req,
	bbp_rsp_if.source          rsp
);

	localparam int  SlotW  = $clog2(TableEntries);
	localparam bit  IsPow2 = (TableEntries & (TableEntries - 1)) == 0;
	localparam int  EntW   = bbp_pkg::CtrW + 1;
	localparam logic [SlotW:0]   Modulus  = (SlotW + 1)'(TableEntries);
	localparam logic [SlotW-1:0] SlotLast = SlotW'(TableEntries - 1);
	localparam int  RecipShift = bbp_pkg::IdxW + SlotW;
	localparam int  RecipW     = bbp_pkg::IdxW + 2;
	localparam int  ProdW      = bbp_pkg::IdxW + RecipW;
	localparam int  MulW       = bbp_pkg::IdxW + SlotW + 1;
	localparam logic [RecipW-1:0] Recip =
		RecipW'((64'd1 << RecipShift) / 64'(TableEntries) + 64'd1);

	// Captured request word.
	logic                            op_q;
	logic [bbp_pkg::IdxW-1:0]        idx_q;
	logic [bbp_pkg::IdxW-1:0]        quot_q;
	logic [bbp_pkg::KindW-1:0]       kind_q;
	logic signed [bbp_pkg::ValW-1:0] val_q;
	logic [bbp_pkg::TgtW-1:0]        tgt_q;
	logic [SlotW-1:0]                slot_q;

	// Each entry holds {target valid, counter}.
	logic [EntW-1:0]  mem [TableEntries];
	logic [EntW-1:0]  rd_q;
	logic [SlotW-1:0] clr_addr_q;

	logic                      out_valid_q;
	logic                      out_pred_q;
	logic                      out_taken_q;
	logic                      out_mis_q;
	logic [bbp_pkg::IdxW-1:0]  out_next_q;

	logic [ProdW-1:0]            recip_prod;
	logic [MulW-1:0]             quot_mul;
	logic [MulW-1:0]             rem_full;
	logic [bbp_pkg::CtrW-1:0]    ctr;
	logic                        ent_valid;
	logic                        pred;
	logic                        is_branch;
	logic                        neg;
	logic                        zero;
	logic                        cond;
	logic [bbp_pkg::CtrW-1:0]    ctr_new;
	logic [bbp_pkg::IdxW-1:0]    seq_idx;
	logic [bbp_pkg::IdxW-1:0]    jump_idx;
	logic                        res_taken;
	logic                        res_mis;
	logic [bbp_pkg::IdxW-1:0]    res_next;
	logic                        wr_en;
	logic [SlotW-1:0]            wr_addr;
	logic [EntW-1:0]             wr_data;

	// Index remainder by reciprocal multiplication. The rounded-up reciprocal gives
	// the exact quotient for every index, so one multiply and subtract yield the slot.
	assign recip_prod = ProdW'(idx_q) * ProdW'(Recip);
	assign quot_mul   = MulW'(quot_q) * MulW'(Modulus);
	assign rem_full   = MulW'(idx_q) - quot_mul;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= req.op;
			idx_q   <= req.instr_index;
			kind_q  <= req.branch_kind;
			val_q   <= req.test_value;
			tgt_q   <= req.target_addr;
			slot_q  <= IsPow2 ? req.instr_index[SlotW-1:0] : '0;
		end else if (cmd.quot_ld) begin
			quot_q  <= bbp_pkg::IdxW'(recip_prod >> RecipShift);
		end else if (cmd.rem_ld) begin
			slot_q  <= rem_full[SlotW-1:0];
		end
	end

	always_comb begin
		ctr       = rd_q[bbp_pkg::CtrW-1:0];
		ent_valid = rd_q[EntW-1];
		pred      = ctr[bbp_pkg::CtrW-1];
		is_branch = (kind_q <= bbp_pkg::KindBltz);
		neg       = val_q[bbp_pkg::ValW-1];
		zero      = (val_q == '0);
		case (kind_q)
			bbp_pkg::KindBez:  cond = zero;
			bbp_pkg::KindBgez: cond = !neg;
			bbp_pkg::KindBlez: cond = neg || zero;
			bbp_pkg::KindBgtz: cond = !neg && !zero;
			bbp_pkg::KindBltz: cond = neg;
			default:           cond = 1'b0;
		endcase
		if (cond) begin
			ctr_new = (ctr == bbp_pkg::CtrMax) ? ctr : ctr + 1'b1;
		end else begin
			ctr_new = (ctr == bbp_pkg::CtrZero) ? ctr : ctr - 1'b1;
		end
		seq_idx  = (idx_q + 1'b1) & bbp_pkg::NextMask;
		jump_idx = tgt_q[bbp_pkg::TgtW-1:2] & bbp_pkg::NextMask;
		if (op_q == bbp_pkg::OpResolve && is_branch) begin
			res_taken = cond;
			res_mis   = cond ? (!ent_valid || !pred) : (ent_valid && pred);
			res_next  = cond ? jump_idx : seq_idx;
		end else begin
			res_taken = 1'b0;
			res_mis   = 1'b0;
			res_next  = (op_q == bbp_pkg::OpPredict && pred && is_branch) ? jump_idx : seq_idx;
		end
		wr_en   = cmd.clear || (cmd.finish && op_q == bbp_pkg::OpResolve && is_branch);
		wr_addr = cmd.clear ? clr_addr_q : slot_q;
		wr_data = cmd.clear ? {1'b0, bbp_pkg::CtrReset} : {1'b1, ctr_new};
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (cmd.rd) rd_q <= mem[slot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear && clr_addr_q != SlotLast) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_pred_q  <= pred;
			out_taken_q <= res_taken;
			out_mis_q   <= res_mis;
			out_next_q  <= res_next;
		end
	end

	assign stat.clear_last = (clr_addr_q == SlotLast);
	assign stat.out_free   = !out_valid_q || rsp.ready;

	assign rsp.valid         = out_valid_q;
	assign rsp.predict_taken = out_pred_q;
	assign rsp.taken         = out_taken_q;
	assign rsp.mispredict    = out_mis_q;
	assign rsp.next_index    = out_next_q;

endmodule

@@ sv/bimodal_branch_predictor.sv @@
// Bimodal branch predictor with 3-bit saturating counters.
// The req channel takes one word per branch event: op selects a fetch-time
// prediction or the resolution of a branch outcome. The rsp channel returns
// exactly one word for each request: predict_taken, taken, mispredict and
// next_index (predicted fetch index, or the redirect index on a resolve).
// Entries are selected by instr_index modulo TableEntries.
// The request is captured in the idle state, its table entry is read in
// the read state and the response is loaded in the evaluate state; when
// TableEntries is not a power of two, a remainder unit built on a
// reciprocal multiplication adds the quotient and remainder states ahead
// of the read. req.ready is high again in the cycle after the response is
// loaded; requests are worked on one at a time, so the next waits for it.
// After reset a clearing sweep writes every entry to counter 3, not valid,
// one entry a cycle; req.ready stays low meanwhile.
// The response sits in an output register: while the receiver stalls it
// holds, the next request is still taken and worked through the table read,
// and it waits in the evaluate state until the register frees.
// Depends on bbp_pkg, bbp_if, bbp_ctrl and bbp_dp.
`timescale 1ns / 1ps
module bimodal_branch_predictor #(
	parameter int TableEntries = bbp_pkg::TableEntriesDef
) (
	input  logic       clk,
	input  logic       arst_n,
	bbp_req_if.sink    req,
	bbp_rsp_if.source  rsp
);

	bbp_pkg::ctl_cmd_t  cmd;
	bbp_pkg::dp_stat_t  stat;

	bbp_ctrl #(
		.TableEntries(TableEntries)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bbp_dp #(
		.TableEntries(TableEntries)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.stat  (stat),
		.req   (req),
		.rsp   (rsp)
	);

endmodule

@@ bench/bimodal_branch_predictor_test.sv @@
// Self-checking testbench of the bimodal branch predictor: predict and resolve words
// against an in-bench copy of the counter and valid tables. Depends on bbp_pkg, bbp_if
// and the bimodal_branch_predictor top level.
`timescale 1ns / 1ps
module bimodal_branch_predictor_test;
	import bbp_pkg::*;

	localparam int CycleLimit = 200000;
	localparam int Slots      = TableEntriesDef;

	typedef struct packed {
		logic                   op;
		logic [IdxW-1:0]        instr_index;
		logic [KindW-1:0]       branch_kind;
		logic signed [ValW-1:0] test_value;
		logic [TgtW-1:0]        target_addr;
	} branch_word_t;

	typedef struct packed {
		logic            predict_taken;
		logic            taken;
		logic            mispredict;
		logic [IdxW-1:0] next_index;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bbp_req_if req_ch();
	bbp_rsp_if rsp_ch();

	bimodal_branch_predictor uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	// Bench copy of the predictor tables.
	logic [CtrW-1:0] ctr_tbl [Slots];
	logic            btb_valid [Slots];

	outcome_t outcome_q [$];
	int errors = 0;
	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	int hold_req = 0;
	int hold_left = 0;
	int cycles = 0;
	logic [IdxW-1:0] hot_base;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("%0t: timed out with %0d words outstanding", $time, outcome_q.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic logic condition_met(input logic [KindW-1:0] kind,
		input logic signed [ValW-1:0] v);
		case (kind)
			KindBez:  return v == 0;
			KindBgez: return v >= 0;
			KindBlez: return v <= 0;
			KindBgtz: return v > 0;
			KindBltz: return v < 0;
			default:  return 1'b0;
		endcase
	endfunction

	// Works out the response to one accepted word and applies its table update.
	function automatic outcome_t bimodal_outcome(input branch_word_t w);
		outcome_t o;
		int unsigned slot;
		logic [CtrW-1:0] ctr;
		logic valid, pred, is_branch, t;
		logic [IdxW-1:0] seq_idx, jump_idx;
		slot = w.instr_index % Slots;
		ctr = ctr_tbl[slot];
		valid = btb_valid[slot];
		pred = ctr[CtrW-1];
		is_branch = w.branch_kind <= KindBltz;
		seq_idx = (w.instr_index + 1'b1) & NextMask;
		jump_idx = w.target_addr[TgtW-1:2] & NextMask;
		o = '0;
		o.predict_taken = pred;
		o.next_index = seq_idx;
		if (w.op == OpPredict) begin
			if (pred && is_branch)
				o.next_index = jump_idx;
		end else if (is_branch) begin
			t = condition_met(w.branch_kind, w.test_value);
			o.taken = t;
			o.mispredict = t ? (!valid || !pred) : (valid && pred);
			o.next_index = t ? jump_idx : seq_idx;
			btb_valid[slot] = 1'b1;
			if (t && ctr != CtrMax)
				ctr_tbl[slot] = ctr + 1'b1;
			else if (!t && ctr != CtrZero)
				ctr_tbl[slot] = ctr - 1'b1;
		end
		return o;
	endfunction

	function automatic void report_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	// Response side: checks each accepted word and drives ready.
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (outcome_q.size() == 0) begin
				$display("%0t: unexpected response word, expected none actual %0h",
					$time, {rsp_ch.predict_taken, rsp_ch.taken, rsp_ch.mispredict,
					rsp_ch.next_index});
				errors++;
			end else begin
				want = outcome_q.pop_front();
				report_field("predict_taken", 32'(want.predict_taken),
					32'(rsp_ch.predict_taken));
				report_field("taken", 32'(want.taken), 32'(rsp_ch.taken));
				report_field("mispredict", 32'(want.mispredict), 32'(rsp_ch.mispredict));
				report_field("next_index", 32'(want.next_index), 32'(rsp_ch.next_index));
			end
		end
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic branch_word_t make_word(input logic op, input logic [IdxW-1:0] idx,
		input logic [KindW-1:0] kind, input logic [ValW-1:0] v, input logic [TgtW-1:0] tgt);
		branch_word_t w;
		w.op = op;
		w.instr_index = idx;
		w.branch_kind = kind;
		w.test_value = v;
		w.target_addr = tgt;
		return w;
	endfunction

	// Offers one word, with random idle cycles ahead of it, and records its outcome
	// at the edge where it is taken.
	task automatic send_word(input branch_word_t w);
		while ($urandom_range(99) < send_gap_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= w.op;
		req_ch.instr_index <= w.instr_index;
		req_ch.branch_kind <= w.branch_kind;
		req_ch.test_value <= w.test_value;
		req_ch.target_addr <= w.target_addr;
		do
			@(posedge clk);
		while (!req_ch.ready);
		outcome_q.push_back(bimodal_outcome(w));
	endtask

	task automatic wait_for_drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outcome_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [ValW-1:0] pick_value();
		case ($urandom_range(6))
			0: return '0;
			1: return '1;
			2: return 32'd1;
			3: return 32'h8000_0000;
			4: return 32'h7FFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [KindW-1:0] pick_kind();
		if ($urandom_range(9) == 0)
			return KindW'($urandom_range(7, KindBltz + 1));
		return KindW'($urandom_range(KindBltz));
	endfunction

	// Mostly a handful of hot slots, so that counters travel to both ends.
	function automatic logic [IdxW-1:0] pick_index();
		if ($urandom_range(3) == 0)
			return IdxW'($urandom_range(65535));
		return {hot_base[IdxW-1:4], 2'b00, 2'($urandom_range(3))} ^ IdxW'($urandom_range(3) << 4);
	endfunction

	task automatic test_directed();
		// Fresh tables: counter 3, nothing valid.
		send_word(make_word(OpPredict, 16'hFFFF, KindBez, 0, 18'h3FFFF));
		send_word(make_word(OpPredict, 16'h0000, 3'd7, '1, 18'h3FFFF));
		send_word(make_word(OpPredict, 16'h1234, KindBgtz, 32'd5, 18'h00004));
		// Taken on an invalid entry is a mispredict.
		send_word(make_word(OpResolve, 16'h0005, KindBez, 0, 18'h3FFFF));
		send_word(make_word(OpPredict, 16'hFFF5, KindBgez, 0, 18'h3FFFC));
		send_word(make_word(OpResolve, 16'h0015, KindBgez, 32'h7FFF_FFFF, 18'h00000));
		// Not taken while valid and predicted taken.
		send_word(make_word(OpResolve, 16'h0025, KindBltz, 32'd1, 18'h2AAAA));
		repeat (4)
			send_word(make_word(OpResolve, 16'h0005, KindBgtz, 32'd1, 18'h15555));
		send_word(make_word(OpResolve, 16'h8005, KindBlez, 32'h8000_0000, 18'h3FFFF));
		// Non-branch kinds never redirect and leave the entry alone.
		send_word(make_word(OpResolve, 16'h0005, 3'd5, 0, 18'h3FFFF));
		send_word(make_word(OpPredict, 16'h0005, 3'd6, 0, 18'h3FFFF));
		send_word(make_word(OpPredict, 16'h0005, KindBltz, '1, 18'h3FFFF));
		send_word(make_word(OpResolve, 16'hFFFF, 3'd7, 32'h8000_0000, 18'h3FFFF));
		repeat (4)
			send_word(make_word(OpResolve, 16'h0009, KindBez, 32'd1, 18'h00100));
		send_word(make_word(OpResolve, 16'h0009, KindBlez, 32'd5, 18'h00100));
		send_word(make_word(OpResolve, 16'h0009, KindBgtz, 32'h8000_0000, 18'h00100));
		send_word(make_word(OpPredict, 16'h0009, KindBez, 0, 18'h3FFFF));
		wait_for_drain();
	endtask

	// Predict then resolve of the same branch, with a little noise between pairs.
	task automatic test_random(input int n_words, input int gap, input int stall);
		int sent;
		branch_word_t w;
		sent = 0;
		send_gap_pct = gap;
		recv_stall_pct = stall;
		hot_base = IdxW'($urandom_range(65535));
		while (sent < n_words) begin
			w = make_word(OpPredict, pick_index(), pick_kind(), pick_value(),
				TgtW'($urandom_range(262143)));
			if ($urandom_range(4) == 0) begin
				w.op = 1'($urandom_range(1));
				send_word(w);
				sent++;
			end else begin
				send_word(w);
				w.op = OpResolve;
				w.test_value = pick_value();
				send_word(w);
				sent += 2;
			end
		end
		wait_for_drain();
	endtask

	// The receiver holds off long enough for the block to fill and stall its input.
	task automatic test_backpressure();
		send_gap_pct = 0;
		recv_stall_pct = 0;
		hold_req = 150;
		hot_base = IdxW'($urandom_range(65535));
		repeat (40)
			send_word(make_word(1'($urandom_range(1)), pick_index(), pick_kind(),
				pick_value(), TgtW'($urandom_range(262143))));
		wait_for_drain();
	endtask

	initial begin
		req_ch.valid <= 1'b0;
		req_ch.op <= OpPredict;
		req_ch.instr_index <= '0;
		req_ch.branch_kind <= KindBez;
		req_ch.test_value <= '0;
		req_ch.target_addr <= '0;
		for (int i = 0; i < Slots; i++) begin
			ctr_tbl[i] = CtrReset;
			btb_valid[i] = 1'b0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(195, 6, 56);
		test_backpressure();
		test_random(195, 56, 6);
		test_random(195, 0, 0);
		recv_stall_pct = 0;
		repeat (20) @(posedge clk);
		if (errors == 0 && outcome_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+sv
sv/bbp_pkg.sv
sv/bbp_if.sv
sv/bbp_ctrl.sv
sv/bbp_dp.sv
sv/bimodal_branch_predictor.sv
bench/bimodal_branch_predictor_test.sv
